// ===== sv/fra_pkg.sv =====
// Shared constants, codes and control word types of the FIFO register allocator.
package fra_pkg;

  // Size of the register pool and derived widths.
  localparam int unsigned NUM_REGS = 11;
  localparam int unsigned IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned CNT_W    = $clog2(NUM_REGS + 1);

  // Field widths of the stream words.
  localparam int unsigned VAR_W    = 16;
  localparam int unsigned OFF_W    = 15;
  localparam int unsigned MOFF_W   = 16;
  localparam int unsigned REG_W    = 4;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned BIAS_W   = 8;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 24;

  // Reset value of the frame bias register.
  localparam logic [BIAS_W-1:0] BIAS_RESET = 8'd36;

  // Input operation codes.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  // Result action codes.
  localparam logic [ACT_W-1:0] ACT_HIT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SPILL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd3;

  // Control word broadcast along a queue chain.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] wpos;
    logic [IDX_W-1:0] wdata;
  } qctl_t;

  // Control word broadcast along the holding cells.
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [VAR_W-1:0] var_id;
    logic [OFF_W-1:0] var_off;
  } hctl_t;

endpackage

// ===== sv/fra_qcell.sv =====
// One cell of a shifting queue chain that holds a physical register index.
module fra_qcell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fra_pkg::IDX_W-1:0] pos_i,
  input  fra_pkg::qctl_t            ctl_i,
  input  logic [fra_pkg::IDX_W-1:0] next_i,
  output logic [fra_pkg::IDX_W-1:0] data_o
);

  logic [fra_pkg::IDX_W-1:0] data_d, data_q;

  // A pop shifts every entry one cell towards the head; a push fills the tail cell.
  always_comb begin
    data_d = data_q;
    if (ctl_i.pop) begin
      data_d = next_i;
    end else if (ctl_i.push && (ctl_i.wpos == pos_i)) begin
      data_d = ctl_i.wdata;
    end
  end

  // The cell starts out holding its own position, which gives the ordered free list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= pos_i;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== sv/fra_hcell.sv =====
// One holding cell: the variable and offset held by one physical register, with its tag compare.
module fra_hcell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [fra_pkg::IDX_W-1:0] pos_i,
  input  fra_pkg::hctl_t            ctl_i,
  input  logic [fra_pkg::VAR_W-1:0] key_i,
  output logic                      match_o,
  output logic [fra_pkg::OFF_W-1:0] off_o
);

  logic                      valid_d, valid_q;
  logic [fra_pkg::VAR_W-1:0] var_q;
  logic [fra_pkg::OFF_W-1:0] off_q;
  logic                      sel;

  assign sel = (ctl_i.idx == pos_i);

  // The valid bit is set on a load and cleared when a flush frees the register.
  always_comb begin
    valid_d = valid_q;
    if (sel && ctl_i.wr) begin
      valid_d = 1'b1;
    end else if (sel && ctl_i.clr) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Tag and offset need no reset; they count only while the valid bit is set.
  always_ff @(posedge clk_i) begin
    if (sel && ctl_i.wr) begin
      var_q <= ctl_i.var_id;
      off_q <= ctl_i.var_off;
    end
  end

  assign match_o = valid_q && (var_q == key_i);
  assign off_o   = off_q;

endmodule

// ===== sv/fifo_register_allocator.sv =====
// Top level of the FIFO register allocator: control sequencer, queue chains and holding cells.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: var_id, var_offset, in_main; tuser: opcode
// m_axis    out  m_axis_tvalid/tready       tdata: reg_index, mem_offset; tuser: action; tlast
// cfg       in   cfg_we_i                   cfg_wdata_i: frame_bias
//
// A request is accepted in ST_IDLE; ST_REQ then searches the holding cells and, once the output
// register is free, emits its result; an eviction adds ST_LOAD for the load.
// A flush emits one spill per cycle while the output register is free, one per used register,
// and emits nothing when no register is used.
// The sequencer works on one word at a time; a stall on m_axis holds it in place.
// Reset is asynchronous and active low and leaves every register free, oldest index first.
module fifo_register_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fra_pkg::S_DATA_W-1:0] s_axis_tdata,  // var_id, var_offset, in_main
  input  logic                         s_axis_tuser,  // opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [fra_pkg::M_DATA_W-1:0] m_axis_tdata,  // reg_index, mem_offset, zero pad
  output logic [fra_pkg::ACT_W-1:0]    m_axis_tuser,  // action
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [fra_pkg::BIAS_W-1:0]   cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_REQ   = 2'd1;
  localparam logic [1:0] ST_LOAD  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam int unsigned N = fra_pkg::NUM_REGS;

  logic [1:0]                    state_d, state_q;
  logic [fra_pkg::BIAS_W-1:0]    bias_q;
  logic [fra_pkg::VAR_W-1:0]     var_q;
  logic [fra_pkg::OFF_W-1:0]     off_q;
  logic                          main_q;
  logic [fra_pkg::IDX_W-1:0]     vic_d, vic_q;
  logic [fra_pkg::CNT_W-1:0]     free_cnt_d, free_cnt_q;
  logic [fra_pkg::CNT_W-1:0]     used_cnt_d, used_cnt_q;

  logic                          m_valid_d, m_valid_q;
  logic [fra_pkg::IDX_W-1:0]     m_reg_d, m_reg_q;
  logic [fra_pkg::ACT_W-1:0]     m_act_d, m_act_q;
  logic [fra_pkg::MOFF_W-1:0]    m_off_d, m_off_q;
  logic                          m_last_d, m_last_q;

  fra_pkg::qctl_t                fctl, uctl;
  fra_pkg::hctl_t                hctl;
  logic [fra_pkg::IDX_W-1:0]     fdata [N];
  logic [fra_pkg::IDX_W-1:0]     udata [N];
  logic [N-1:0]                  match;
  logic [fra_pkg::OFF_W-1:0]     held_off [N];

  logic                          accept;
  logic                          out_free;
  logic                          emit;
  logic                          hit_any;
  logic [fra_pkg::IDX_W-1:0]     hit_idx;
  logic [fra_pkg::OFF_W-1:0]     emit_src;
  logic [fra_pkg::MOFF_W-1:0]    emit_off;
  logic [fra_pkg::MOFF_W-1:0]    bias_add;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Free and used queues: chains of cells with the oldest entry in cell zero.
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1 < N) ? i + 1 : i;

    fra_qcell u_free (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (fra_pkg::IDX_W'(i)),
      .ctl_i  (fctl),
      .next_i (fdata[NXT]),
      .data_o (fdata[i])
    );

    fra_qcell u_used (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (fra_pkg::IDX_W'(i)),
      .ctl_i  (uctl),
      .next_i (udata[NXT]),
      .data_o (udata[i])
    );

    fra_hcell u_hold (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pos_i   (fra_pkg::IDX_W'(i)),
      .ctl_i   (hctl),
      .key_i   (var_q),
      .match_o (match[i]),
      .off_o   (held_off[i])
    );
  end

  // Lowest matching register wins the hit.
  always_comb begin
    hit_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = fra_pkg::IDX_W'(i);
      end
    end
  end
  assign hit_any = |match;

  // Offsets leave with the frame bias unless the code is for main.
  assign bias_add = main_q ? '0 : fra_pkg::MOFF_W'(bias_q);
  assign emit_off = fra_pkg::MOFF_W'(emit_src) + bias_add;

  // Sequencer for requests, evictions and flushes.
  always_comb begin
    state_d       = state_q;
    vic_d         = vic_q;
    free_cnt_d    = free_cnt_q;
    used_cnt_d    = used_cnt_q;
    s_axis_tready = 1'b0;
    fctl          = '0;
    uctl          = '0;
    hctl          = '0;
    hctl.var_id   = var_q;
    hctl.var_off  = off_q;
    emit          = 1'b0;
    emit_src      = off_q;
    m_reg_d       = m_reg_q;
    m_act_d       = m_act_q;
    m_last_d      = m_last_q;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == fra_pkg::OP_FLUSH) ? ST_FLUSH : ST_REQ;
        end
      end

      ST_REQ: begin
        if (out_free) begin
          if (hit_any) begin
            emit     = 1'b1;
            m_reg_d  = hit_idx;
            m_act_d  = fra_pkg::ACT_HIT;
            m_last_d = 1'b1;
            state_d  = ST_IDLE;
          end else if (free_cnt_q != '0) begin
            // Take the oldest free register and load the variable into it.
            fctl.pop   = 1'b1;
            free_cnt_d = free_cnt_q - 1'b1;
            uctl.push  = 1'b1;
            uctl.wpos  = used_cnt_q[fra_pkg::IDX_W-1:0];
            uctl.wdata = fdata[0];
            used_cnt_d = used_cnt_q + 1'b1;
            hctl.wr    = 1'b1;
            hctl.idx   = fdata[0];
            emit       = 1'b1;
            m_reg_d    = fdata[0];
            m_act_d    = fra_pkg::ACT_LOAD;
            m_last_d   = 1'b1;
            state_d    = ST_IDLE;
          end else if (used_cnt_q != '0) begin
            // Evict the oldest used register; its load follows in the next state.
            uctl.pop   = 1'b1;
            used_cnt_d = used_cnt_q - 1'b1;
            vic_d      = udata[0];
            emit       = 1'b1;
            emit_src   = held_off[udata[0]];
            m_reg_d    = udata[0];
            m_act_d    = fra_pkg::ACT_SPILL;
            m_last_d   = 1'b0;
            state_d    = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_LOAD: begin
        if (out_free) begin
          uctl.push  = 1'b1;
          uctl.wpos  = used_cnt_q[fra_pkg::IDX_W-1:0];
          uctl.wdata = vic_q;
          used_cnt_d = used_cnt_q + 1'b1;
          hctl.wr    = 1'b1;
          hctl.idx   = vic_q;
          emit       = 1'b1;
          m_reg_d    = vic_q;
          m_act_d    = fra_pkg::ACT_LOAD;
          m_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (used_cnt_q == '0) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          // Spill the oldest used register and return it to the free tail.
          uctl.pop   = 1'b1;
          used_cnt_d = used_cnt_q - 1'b1;
          fctl.push  = 1'b1;
          fctl.wpos  = free_cnt_q[fra_pkg::IDX_W-1:0];
          fctl.wdata = udata[0];
          free_cnt_d = free_cnt_q + 1'b1;
          hctl.clr   = 1'b1;
          hctl.idx   = udata[0];
          emit       = 1'b1;
          emit_src   = held_off[udata[0]];
          m_reg_d    = udata[0];
          m_act_d    = fra_pkg::ACT_FLUSH;
          m_last_d   = (used_cnt_q == fra_pkg::CNT_W'(1));
          if (used_cnt_q == fra_pkg::CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded on emit, emptied when the word is taken.
  always_comb begin
    m_valid_d = m_valid_q;
    m_off_d   = m_off_q;
    if (emit) begin
      m_valid_d = 1'b1;
      m_off_d   = (m_act_d == fra_pkg::ACT_HIT) ? '0 : emit_off;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      free_cnt_q <= fra_pkg::CNT_W'(N);
      used_cnt_q <= '0;
      m_valid_q  <= 1'b0;
      bias_q     <= fra_pkg::BIAS_RESET;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      used_cnt_q <= used_cnt_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        bias_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      var_q  <= s_axis_tdata[fra_pkg::VAR_W-1:0];
      off_q  <= s_axis_tdata[fra_pkg::VAR_W +: fra_pkg::OFF_W];
      main_q <= s_axis_tdata[fra_pkg::VAR_W + fra_pkg::OFF_W];
    end
    vic_q    <= vic_d;
    m_reg_q  <= m_reg_d;
    m_act_q  <= m_act_d;
    m_off_q  <= m_off_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(fra_pkg::M_DATA_W - fra_pkg::REG_W - fra_pkg::MOFF_W){1'b0}},
                          m_off_q, fra_pkg::REG_W'(m_reg_q)};
  assign m_axis_tuser  = m_act_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== sv/fra_checker.sv =====
// Port-level assertions for the FIFO register allocator and the bind that attaches them.
module fra_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [fra_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [fra_pkg::ACT_W-1:0]    m_axis_tuser,
  input logic                         m_axis_tlast
);

  // A stalled result word keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // A hit carries no memory offset.
  a_hit_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == fra_pkg::ACT_HIT) |->
      (m_axis_tdata[fra_pkg::REG_W +: fra_pkg::MOFF_W] == '0))
    else $error("hit with a nonzero offset");

  // Hits and loads close a request; an eviction spill never does.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tlast == ((m_axis_tuser == fra_pkg::ACT_HIT) ||
                        (m_axis_tuser == fra_pkg::ACT_LOAD)))
      || (m_axis_tuser == fra_pkg::ACT_FLUSH))
    else $error("last flag does not fit the action");

  // Every result names a register of the pool.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[fra_pkg::REG_W-1:0] < fra_pkg::REG_W'(fra_pkg::NUM_REGS)))
    else $error("register index outside the pool");

  // A taken eviction spill may only be followed at once by no word or by the load of the same register.
  a_spill_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == fra_pkg::ACT_SPILL) |=>
      !m_axis_tvalid || ((m_axis_tuser == fra_pkg::ACT_LOAD) &&
      (m_axis_tdata[fra_pkg::REG_W-1:0] == $past(m_axis_tdata[fra_pkg::REG_W-1:0]))))
    else $error("eviction spill not followed by its load");

endmodule

bind fifo_register_allocator fra_checker u_fra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
